[hw/rtl/ftr_pkg.sv]
// Shared types and constants of the FLV tag timestamp rebaser.
package ftr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] TAG_TYPE_AUDIO = 8'h08;
  localparam logic [7:0] TAG_TYPE_VIDEO = 8'h09;
  localparam logic [31:0] HDR_LEN = 32'd11;

  // One input transaction.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       tag_end;
    logic       run_last;
  } out_item_t;

  // Work handed from the parser to the emitter: all bytes caused by one
  // input byte, sent in index order 0..last_idx.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            tag_end;
  } entry_t;

endpackage

[hw/rtl/ftr_front.sv]
// Tag parser: tracks header, body and trailer and builds output entries.
module ftr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ftr_pkg::in_item_t in_item,
  output logic             full,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output ftr_pkg::entry_t  q_entry
);
  import ftr_pkg::*;

  typedef enum logic [1:0] {
    SEC_HEADER  = 2'd0,
    SEC_BODY    = 2'd1,
    SEC_TRAILER = 2'd2
  } section_t;

  localparam logic [3:0] POS_TYPE     = 4'd0;
  localparam logic [3:0] POS_SIZE_HI  = 4'd1;
  localparam logic [3:0] POS_SIZE_LO  = 4'd3;
  localparam logic [3:0] POS_STAMP_HI = 4'd4;
  localparam logic [3:0] POS_STAMP_LO = 4'd6;
  localparam logic [3:0] POS_STAMP_EX = 4'd7;
  localparam logic [3:0] POS_HDR_LAST = 4'd10;
  localparam logic [1:0] TRL_LAST     = 2'd3;

  section_t    section, section_next;
  logic [3:0]  position, position_next;
  logic        keep_tag, keep_tag_next;
  logic [23:0] body_size, body_size_next;
  logic [23:0] body_left, body_left_next;
  logic [23:0] stamp_low, stamp_low_next;
  logic [31:0] timestamp_offset;

  logic        accept;
  logic [7:0]  b;
  section_t    sec_eff;
  logic [3:0]  pos_eff;
  logic [3:0]  p;
  logic [1:0]  tp;
  logic [23:0] left_dec;
  logic [31:0] total;
  logic [31:0] ts;
  logic        emit;

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign b         = in_item.in_byte;

  // Trailer value and rebased timestamp.
  assign total = {8'd0, body_size} + HDR_LEN;
  assign ts    = {b, stamp_low} + timestamp_offset;

  // Classify the byte and work out the next state and the entry it causes.
  always_comb begin
    sec_eff        = in_item.file_start ? SEC_HEADER : section;
    pos_eff        = in_item.file_start ? POS_TYPE : position;
    section_next   = sec_eff;
    position_next  = pos_eff;
    keep_tag_next  = keep_tag;
    body_size_next = body_size;
    body_left_next = body_left;
    stamp_low_next = stamp_low;
    left_dec       = body_left - 24'd1;
    tp             = pos_eff[1:0];
    p              = pos_eff;
    emit           = 1'b0;
    q_entry        = '0;
    q_entry.data[0] = b;
    case (sec_eff)
      SEC_BODY: begin
        emit           = keep_tag;
        body_left_next = left_dec;
        if (left_dec == 24'd0) begin
          section_next  = SEC_TRAILER;
          position_next = POS_TYPE;
        end
      end
      SEC_TRAILER: begin
        emit             = keep_tag;
        q_entry.data[0]  = total[8 * (3 - tp) +: 8];
        q_entry.tag_end  = (tp == TRL_LAST);
        if (tp == TRL_LAST) begin
          section_next  = SEC_HEADER;
          position_next = POS_TYPE;
        end else begin
          position_next = {2'b00, tp + 2'd1};
        end
      end
      default: begin
        // An out-of-range position restarts the header; the unused section code is parsed as header.
        if (pos_eff > POS_HDR_LAST) begin
          p = POS_TYPE;
        end
        if (p == POS_TYPE) begin
          keep_tag_next  = (b == TAG_TYPE_AUDIO) || (b == TAG_TYPE_VIDEO);
          body_size_next = '0;
          stamp_low_next = '0;
        end
        if (p >= POS_SIZE_HI && p <= POS_SIZE_LO) begin
          body_size_next = {body_size[15:0], b};
        end
        if (p >= POS_STAMP_HI && p <= POS_STAMP_LO) begin
          stamp_low_next = {stamp_low[15:0], b};
        end else if (p == POS_STAMP_EX) begin
          // Send all four timestamp bytes in tag order.
          emit             = keep_tag;
          q_entry.data[0]  = ts[23:16];
          q_entry.data[1]  = ts[15:8];
          q_entry.data[2]  = ts[7:0];
          q_entry.data[3]  = ts[31:24];
          q_entry.last_idx = 2'd3;
        end else begin
          emit = keep_tag_next;
        end
        if (p == POS_HDR_LAST) begin
          body_left_next = body_size_next;
          section_next   = (body_size_next != 24'd0) ? SEC_BODY : SEC_TRAILER;
          position_next  = POS_TYPE;
        end else begin
          section_next  = SEC_HEADER;
          position_next = p + 4'd1;
        end
      end
    endcase
  end

  assign q_push = accept && emit;

  // Advance parser state on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      section   <= SEC_HEADER;
      position  <= '0;
      keep_tag  <= 1'b0;
      body_size <= '0;
      body_left <= '0;
      stamp_low <= '0;
    end else if (accept) begin
      section   <= section_next;
      position  <= position_next;
      keep_tag  <= keep_tag_next;
      body_size <= body_size_next;
      body_left <= body_left_next;
      stamp_low <= stamp_low_next;
    end
  end

  // Hold the timestamp offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      timestamp_offset <= cfg_data;
    end
  end

endmodule

[hw/rtl/ftr_queue.sv]
// Short entry queue between the parser and the emitter.
module ftr_queue #(
  parameter int unsigned DEPTH = ftr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ftr_pkg::entry_t wr_entry,
  output logic            q_full,
  output logic            q_valid,
  input  logic            rd_en,
  output ftr_pkg::entry_t rd_entry
);
  import ftr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full   = (count == CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && q_valid;
  assign rd_entry = slots[rd_ptr];

  // Store entries at the write pointer.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and track the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/ftr_back.sv]
// Emitter: splits queued entries into single output byte transactions.
module ftr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ftr_pkg::entry_t    q_entry,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output ftr_pkg::out_item_t out_item
);
  import ftr_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_last;
  logic       take;

  assign at_last = (idx == cur.last_idx);
  assign take    = pop && cur_valid;
  assign q_pop   = q_valid && (!cur_valid || (take && at_last));
  assign empty   = !cur_valid;

  assign out_item.out_byte = cur.data[idx];
  assign out_item.tag_end  = cur.tag_end && at_last;
  assign out_item.run_last = at_last;

  // Hold the current entry; step through its bytes, then load the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (take) begin
        if (at_last) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

endmodule

[hw/rtl/flv_tag_timestamp_rebaser_top.sv]
// Top level of the FLV tag timestamp rebaser: parser, entry queue, emitter.
//
//   channel   direction  handshake           payload
//   input     in         push / full         in_item  (in_byte, file_start)
//   result    out        empty / pop         out_item (out_byte, tag_end, run_last)
//   config    in         cfg_valid/cfg_ready cfg_data (timestamp_offset)
//
// One input byte is taken per cycle while the entry queue has room; each
// byte's results go out at one per cycle while pop is high, so the four
// timestamp bytes of a kept tag leave one at a time; the queue absorbs that.
// The emitter's current-entry register holds the result while pop is low.
// rst is synchronous and clears the parser state, the offset, the queue and
// the emitter; no clearing pass is needed.
module flv_tag_timestamp_rebaser_top #(
  parameter int unsigned QUEUE_DEPTH = ftr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ftr_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output ftr_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import ftr_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_wr_entry;
  logic   q_valid;
  logic   q_pop;
  entry_t q_rd_entry;

  ftr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  ftr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .rd_en    (q_pop),
    .rd_entry (q_rd_entry)
  );

  ftr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // The parser never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("entry written while queue full");

  // The emitter only loads an entry that is there.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("entry taken from empty queue");

  // A trailer end byte is always the last byte of its run.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.tag_end) |-> out_item.run_last)
    else $error("tag_end without run_last");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the FLV tag timestamp rebaser: tag streams in, rebased bytes checked.
module testbench;
  import ftr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TARGET_BYTES  = 420;

  // Byte positions inside a tag header and trailer.
  localparam int SIZE_FIRST   = 1;
  localparam int SIZE_LAST    = 3;
  localparam int STAMP_FIRST  = 4;
  localparam int STAMP_LAST   = 6;
  localparam int STAMP_HIGH   = 7;
  localparam int HDR_LAST     = HDR_LEN - 1;
  localparam int TRAILER_LEN  = 4;
  localparam int TRAILER_LAST = TRAILER_LEN - 1;

  localparam logic [7:0] TAG_TYPE_SCRIPT = 8'h12;

  typedef enum logic [1:0] {
    SEC_HEADER,
    SEC_BODY,
    SEC_TRAILER
  } tag_section_e;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [31:0] cfg_data;

  // Predictor state
  tag_section_e tag_section;
  int unsigned  tag_pos;
  logic         tag_kept;
  logic [23:0]  tag_body_size;
  logic [23:0]  tag_body_left;
  logic [23:0]  stamp_low24;
  logic [31:0]  rebase_offset;

  out_item_t rebased_due[$];
  int        fail_count;
  int        bytes_sent;
  int        cycle_count;
  int        tx_idle_max;
  int        rx_idle_max;
  int        rx_stall_req;

  flv_tag_timestamp_rebaser_top DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out the rebased bytes caused by one accepted input byte.
  function automatic void rebase_byte(input in_item_t it);
    out_item_t   caused[$];
    logic [7:0]  b;
    logic [31:0] total;
    logic [31:0] ts;
    int unsigned p;
    b = it.in_byte;
    if (it.file_start) begin
      tag_section = SEC_HEADER;
      tag_pos = 0;
    end
    case (tag_section)
      SEC_BODY: begin
        if (tag_kept) caused.push_back('{out_byte: b, tag_end: 1'b0, run_last: 1'b0});
        tag_body_left = tag_body_left - 24'd1;
        if (tag_body_left == 24'd0) begin
          tag_section = SEC_TRAILER;
          tag_pos = 0;
        end
      end
      SEC_TRAILER: begin
        total = {8'h00, tag_body_size} + HDR_LEN;
        p = tag_pos % TRAILER_LEN;
        if (tag_kept)
          caused.push_back('{out_byte: 8'(total >> (8 * (TRAILER_LAST - p))),
                             tag_end: (p == TRAILER_LAST), run_last: 1'b0});
        if (p == TRAILER_LAST) begin
          tag_section = SEC_HEADER;
          tag_pos = 0;
        end else begin
          tag_pos = p + 1;
        end
      end
      default: begin
        p = (tag_pos > HDR_LAST) ? 0 : tag_pos;
        if (p == 0) begin
          tag_kept = (b == TAG_TYPE_AUDIO) || (b == TAG_TYPE_VIDEO);
          tag_body_size = '0;
          stamp_low24 = '0;
        end
        if (p >= SIZE_FIRST && p <= SIZE_LAST) tag_body_size = {tag_body_size[15:0], b};
        if (p >= STAMP_FIRST && p <= STAMP_LAST) begin
          stamp_low24 = {stamp_low24[15:0], b};
        end else if (p == STAMP_HIGH) begin
          if (tag_kept) begin
            ts = {b, stamp_low24} + rebase_offset;
            caused.push_back('{out_byte: ts[23:16], tag_end: 1'b0, run_last: 1'b0});
            caused.push_back('{out_byte: ts[15:8], tag_end: 1'b0, run_last: 1'b0});
            caused.push_back('{out_byte: ts[7:0], tag_end: 1'b0, run_last: 1'b0});
            caused.push_back('{out_byte: ts[31:24], tag_end: 1'b0, run_last: 1'b0});
          end
        end else if (tag_kept) begin
          caused.push_back('{out_byte: b, tag_end: 1'b0, run_last: 1'b0});
        end
        if (p == HDR_LAST) begin
          tag_body_left = tag_body_size;
          tag_section = (tag_body_size != 24'd0) ? SEC_BODY : SEC_TRAILER;
          tag_pos = 0;
        end else begin
          tag_section = SEC_HEADER;
          tag_pos = p + 1;
        end
      end
    endcase
    if (caused.size() > 0) caused[caused.size() - 1].run_last = 1'b1;
    foreach (caused[i]) rebased_due.push_back(caused[i]);
  endfunction

  // Offer one byte; push stays high on return so back-to-back bytes need no toggle.
  task automatic send_item(input logic [7:0] b, input logic fs);
    in_item_t it;
    int       gap;
    it = '{in_byte: b, file_start: fs};
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    rebase_byte(it);
    bytes_sent++;
  endtask

  // Send one tag; stop_at >= 0 cuts it off before that byte index.
  task automatic send_tag(input logic [7:0] kind, input logic [23:0] size,
                          input logic [31:0] stamp, input logic restart, input int stop_at);
    longint     tag_len;
    longint     idx;
    logic [7:0] b;
    tag_len = HDR_LEN + longint'(size) + TRAILER_LEN;
    idx = 0;
    while (idx < tag_len && (stop_at < 0 || idx < stop_at)) begin
      case (idx)
        0: b = kind;
        1: b = size[23:16];
        2: b = size[15:8];
        3: b = size[7:0];
        4: b = stamp[23:16];
        5: b = stamp[15:8];
        6: b = stamp[7:0];
        7: b = stamp[31:24];
        default: b = 8'($urandom);
      endcase
      send_item(b, restart && (idx == 0));
      idx++;
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_item(8'($urandom), ($urandom_range(0, 7) == 0));
  endtask

  // Hold the input until every expected transaction has come out, then let the block settle.
  task automatic drain();
    push <= 1'b0;
    while (rebased_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rebase_offset = value;
  endtask

  // Tests
  task automatic test_tag_types();
    send_tag(TAG_TYPE_AUDIO, 24'd3, 32'h0012_3456, 1'b1, -1);
    send_tag(TAG_TYPE_VIDEO, 24'd1, 32'hFFFF_FFFF, 1'b0, -1);
    send_tag(TAG_TYPE_SCRIPT, 24'd2, 32'h0000_0000, 1'b0, -1);
    send_tag(8'hFF, 24'd0, 32'h8000_0000, 1'b0, -1);
    drain();
  endtask

  task automatic test_empty_body();
    send_tag(TAG_TYPE_VIDEO, 24'd0, 32'h0000_0000, 1'b1, -1);
    send_tag(TAG_TYPE_AUDIO, 24'd0, 32'h7F00_00FF, 1'b0, -1);
    drain();
  endtask

  task automatic test_offset_extremes();
    write_offset(32'hFFFF_FFFF);
    send_tag(TAG_TYPE_VIDEO, 24'd1, 32'hFFFF_FFFF, 1'b1, -1);
    send_tag(TAG_TYPE_AUDIO, 24'd0, 32'h0000_0001, 1'b0, -1);
    write_offset(32'h8000_0000);
    send_tag(TAG_TYPE_AUDIO, 24'd2, 32'h8000_0000, 1'b0, -1);
    drain();
  endtask

  task automatic test_file_start_mid_tag();
    // abandon in the body of a huge tag, in the header, and in the trailer
    send_tag(TAG_TYPE_AUDIO, 24'hFF_FFFF, 32'h0101_0101, 1'b1, HDR_LEN + 3);
    send_tag(TAG_TYPE_VIDEO, 24'd2, 32'h0A0B_0C0D, 1'b1, 5);
    send_tag(TAG_TYPE_AUDIO, 24'd1, 32'h0000_1000, 1'b1, HDR_LEN + 3);
    send_tag(TAG_TYPE_VIDEO, 24'hAA_5500, 32'h5A5A_A5A5, 1'b1, STAMP_HIGH + 1);
    send_tag(TAG_TYPE_VIDEO, 24'd1, 32'h0000_0002, 1'b1, -1);
    drain();
  endtask

  task automatic test_queue_backpressure();
    tx_idle_max = 0;
    rx_stall_req = 120;
    send_tag(TAG_TYPE_VIDEO, 24'd40, 32'($urandom), 1'b1, -1);
    drain();
    tx_idle_max = 7;
  endtask

  task automatic test_random_streams();
    int tag_count;
    int pick;
    int body;
    tag_count = 0;
    while (bytes_sent < TARGET_BYTES) begin
      // change offset and idling at phase boundaries
      if (tag_count % 8 == 7) begin
        case ($urandom_range(0, 3))
          0: write_offset(32'h0000_0000);
          1: write_offset(32'hFFFF_FFFF);
          default: write_offset(32'($urandom));
        endcase
        tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
        rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      end
      pick = $urandom_range(0, 99);
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (pick < 70) begin
        send_tag($urandom_range(0, 1) ? TAG_TYPE_VIDEO : TAG_TYPE_AUDIO, 24'(body),
                 32'($urandom), ($urandom_range(0, 3) == 0), -1);
      end else if (pick < 80) begin
        send_tag(8'($urandom), 24'(body), 32'($urandom), 1'b0, -1);
      end else if (pick < 90) begin
        send_tag(TAG_TYPE_AUDIO + 8'($urandom_range(0, 1)), 24'($urandom), 32'($urandom),
                 1'b1, $urandom_range(1, HDR_LEN + 6));
        send_tag(TAG_TYPE_VIDEO, 24'($urandom_range(0, 4)), 32'($urandom), 1'b1, -1);
      end else begin
        send_noise($urandom_range(1, 6));
        send_tag(TAG_TYPE_AUDIO, 24'($urandom_range(0, 4)), 32'($urandom), 1'b1, -1);
      end
      tag_count++;
    end
    drain();
  endtask

  // Result side: random pop gaps, plus a long hold when one is requested.
  initial begin
    int gap;
    pop <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = $urandom_range(0, rx_idle_max);
      if (rx_stall_req > 0) begin
        gap = rx_stall_req;
        rx_stall_req = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Check each accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (rebased_due.size() == 0) begin
        $error("unexpected result: out_byte %02h tag_end %0b run_last %0b",
               out_item.out_byte, out_item.tag_end, out_item.run_last);
        fail_count++;
      end else begin
        want = rebased_due.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
          fail_count++;
        end
        if (out_item.tag_end !== want.tag_end) begin
          $error("tag_end: expected %0b, got %0b", want.tag_end, out_item.tag_end);
          fail_count++;
        end
        if (out_item.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_item.run_last);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    cycle_count = 0;
    fail_count = 0;
    bytes_sent = 0;
    tx_idle_max = 7;
    rx_idle_max = 7;
    rx_stall_req = 0;
    tag_section = SEC_HEADER;
    tag_pos = 0;
    tag_kept = 1'b0;
    tag_body_size = '0;
    tag_body_left = '0;
    stamp_low24 = '0;
    rebase_offset = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_tag_types();
    test_empty_body();
    test_offset_extremes();
    test_file_start_mid_tag();
    test_queue_backpressure();
    test_random_streams();

    drain();
    if (fail_count == 0 && rebased_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
